FILE: hdl/ibfd_pkg.sv
package ibfd_pkg;

  localparam int PIX_W     = 24;
  localparam int COORD_W   = 12;
  localparam int CFG_W     = 13;
  localparam int OWN_LANES = PIX_W - 1;
  localparam int FLAG_W    = 2 * PIX_W;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } ibfd_reg_e;

  // One pixel that may carry warnings, with its position as reported
  typedef struct packed {
    logic [PIX_W-1:0]   pix;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } ibfd_site_t;

  // Warnings of one request: held pixel first, then the closing pixel of an image.
  // flags[PIX_W-1:0] belong to held, flags[FLAG_W-1:PIX_W] to own; bit p is stream bit p.
  typedef struct packed {
    ibfd_site_t        held;
    ibfd_site_t        own;
    logic [FLAG_W-1:0] flags;
  } ibfd_job_t;

endpackage

FILE: hdl/ibfd_lane.sv
module ibfd_lane (
  input  logic [3:0] win_i,   // two bits before, the bit, the bit after
  input  logic       en_i,
  output logic       flag_o
);

  assign flag_o = en_i && (win_i[3] == win_i[2]) && (win_i[0] == win_i[2]) &&
                  (win_i[1] != win_i[2]);

endmodule

FILE: hdl/ibfd_intake.sv
module ibfd_intake #(
  parameter int MAX_DIM = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [ibfd_pkg::CFG_W-1:0]  width_i,
  input  logic [ibfd_pkg::CFG_W-1:0]  height_i,
  input  logic [ibfd_pkg::PIX_W-1:0]  pix_i,
  input  logic                        accept_i,
  output ibfd_pkg::ibfd_job_t         job_o,
  output logic                        push_o
);

  localparam int DimW = $clog2(MAX_DIM + 1);
  localparam int CntW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int PW   = ibfd_pkg::PIX_W;
  localparam int OL   = ibfd_pkg::OWN_LANES;

  logic [PW-1:0]   held_q, held_d;
  logic            held_v_q, held_v_d;
  logic [CntW-1:0] col_q, col_d, row_q, row_d;
  logic [OL-1:0]   pend_q, pend_d;

  logic [DimW-1:0] w_eff, h_eff;
  logic [CntW:0]   col_inc, row_inc;
  logic [CntW-1:0] col_n, row_n;
  logic            first, last;
  logic [1:0]      e2;
  logic [PW+1:0]   seq;
  logic [OL-1:0]   own_flags;
  logic            held_flag;
  logic [PW-1:0]   flags_a, flags_b;

  always_comb begin
    w_eff = (width_i == '0) ? DimW'(1) :
            ((32'(width_i) > 32'(MAX_DIM)) ? DimW'(MAX_DIM) : DimW'(width_i));
    h_eff = (height_i == '0) ? DimW'(1) :
            ((32'(height_i) > 32'(MAX_DIM)) ? DimW'(MAX_DIM) : DimW'(height_i));
  end

  // Advance the position past the held pixel
  always_comb begin
    col_inc = {1'b0, col_q} + 1'b1;
    row_inc = {1'b0, row_q} + 1'b1;
    col_n   = col_q;
    row_n   = row_q;
    if (held_v_q) begin
      if (32'(col_inc) >= 32'(w_eff)) begin
        col_n = '0;
        row_n = (32'(row_inc) >= 32'(h_eff)) ? '0 : row_inc[CntW-1:0];
      end else begin
        col_n = col_inc[CntW-1:0];
      end
    end
    first = (col_n == '0) && (row_n == '0);
    last  = (32'(col_n) + 32'd1 == 32'(w_eff)) && (32'(row_n) + 32'd1 == 32'(h_eff));
    e2    = first ? 2'b00 : held_q[1:0];
  end

  // Stream bits around the new pixel, oldest first
  always_comb begin
    seq[0] = e2[1];
    seq[1] = e2[0];
    for (int p = 0; p < PW; p++) begin
      seq[p+2] = pix_i[PW-1-p];
    end
  end

  for (genvar p = 0; p < OL; p++) begin : g_lane
    logic en;
    if (p < 2) begin : g_head
      assign en = !first;
    end else begin : g_body
      assign en = 1'b1;
    end
    ibfd_lane u_lane (
      .win_i  ({seq[p], seq[p+1], seq[p+2], seq[p+3]}),
      .en_i   (en),
      .flag_o (own_flags[p])
    );
  end

  // Last bit of the held pixel needs the first bit of the new one
  ibfd_lane u_lane_tail (
    .win_i  ({held_q[2], held_q[1], held_q[0], pix_i[PW-1]}),
    .en_i   (held_v_q),
    .flag_o (held_flag)
  );

  always_comb begin
    flags_a = held_v_q ? {held_flag, pend_q} : '0;
    flags_b = last ? {1'b0, own_flags} : '0;

    job_o.held.pix = held_q;
    job_o.held.x   = ibfd_pkg::COORD_W'(col_q);
    job_o.held.y   = ibfd_pkg::COORD_W'(32'(h_eff) - 32'd1 - 32'(row_q));
    job_o.own.pix  = pix_i;
    job_o.own.x    = ibfd_pkg::COORD_W'(col_n);
    job_o.own.y    = ibfd_pkg::COORD_W'(32'(h_eff) - 32'd1 - 32'(row_n));
    job_o.flags    = {flags_b, flags_a};
    push_o         = accept_i && (job_o.flags != '0);
  end

  always_comb begin
    held_d   = held_q;
    held_v_d = held_v_q;
    col_d    = col_q;
    row_d    = row_q;
    pend_d   = pend_q;
    if (accept_i) begin
      if (last) begin
        // close the image
        held_d   = '0;
        held_v_d = 1'b0;
        col_d    = '0;
        row_d    = '0;
        pend_d   = '0;
      end else begin
        held_d   = pix_i;
        held_v_d = 1'b1;
        col_d    = col_n;
        row_d    = row_n;
        pend_d   = own_flags;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= '0;
      held_v_q <= 1'b0;
      col_q    <= '0;
      row_q    <= '0;
      pend_q   <= '0;
    end else begin
      held_q   <= held_d;
      held_v_q <= held_v_d;
      col_q    <= col_d;
      row_q    <= row_d;
      pend_q   <= pend_d;
    end
  end

  a_idle_at_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !held_v_q |-> (col_q == '0) && (row_q == '0) && (pend_q == '0))
    else $error("no held pixel but position or flags left over");

endmodule

FILE: hdl/ibfd_merge.sv
module ibfd_merge (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ibfd_pkg::ibfd_job_t         job_i,
  input  logic                        push_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output ibfd_pkg::ibfd_site_t        warn_o,
  output logic                        warn_last_o
);

  localparam int PW = ibfd_pkg::PIX_W;
  localparam int FW = ibfd_pkg::FLAG_W;

  ibfd_pkg::ibfd_job_t cur_q, cur_d, pend_q, pend_d;
  logic                cur_v_q, cur_v_d, pend_v_q, pend_v_d;

  logic [FW-1:0] lowbit, rest;
  logic          sel_own, done;
  logic [PW-1:0] oh, flip;
  ibfd_pkg::ibfd_site_t site;

  // Pick the earliest flagged bit of the current request
  always_comb begin
    lowbit  = cur_q.flags & (~cur_q.flags + 1'b1);
    rest    = cur_q.flags & ~lowbit;
    sel_own = |lowbit[FW-1:PW];
    oh      = sel_own ? lowbit[FW-1:PW] : lowbit[PW-1:0];
    for (int i = 0; i < PW; i++) begin
      flip[PW-1-i] = oh[i];
    end
    site        = sel_own ? cur_q.own : cur_q.held;
    warn_o.pix  = site.pix ^ flip;
    warn_o.x    = site.x;
    warn_o.y    = site.y;
    warn_last_o = (rest == '0);
    out_valid_o = cur_v_q;
    in_ready_o  = !pend_v_q;
    done        = cur_v_q && out_ready_i && (rest == '0);
  end

  always_comb begin
    cur_d    = cur_q;
    cur_v_d  = cur_v_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    if (!cur_v_q || done) begin
      if (pend_v_q) begin
        cur_d    = pend_q;
        cur_v_d  = 1'b1;
        pend_v_d = 1'b0;
      end else if (push_i) begin
        cur_d   = job_i;
        cur_v_d = 1'b1;
      end else begin
        cur_v_d = 1'b0;
      end
    end else begin
      if (out_ready_i) begin
        cur_d.flags = rest;
      end
      if (push_i) begin
        pend_d   = job_i;
        pend_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      cur_v_q  <= cur_v_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    pend_q <= pend_d;
  end

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> cur_v_q)
    else $error("queued request while output slot is empty");

  a_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_v_q |-> (cur_q.flags != '0))
    else $error("active request carries no warnings");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !pend_v_q)
    else $error("request pushed into a full queue");

endmodule

FILE: hdl/isolated_bit_flip_detector.sv
// Output: a pixel's warnings are registered in the merge once the next pixel is accepted
// (or once itself is, for the last pixel of an image), then leave one warning per cycle
// while m_axis_tready is high. Throughput: 1 pixel per cycle; intake stalls only while two
// requests with warnings wait, as the single output port drains one warning per cycle.
// Reset: image_width and image_height return to 1, no pixel is held, position is 0,0.
module isolated_bit_flip_detector #(
  parameter int MAX_DIM = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // warn_x, warn_y, warn_red, warn_green, warn_blue
  output logic        m_axis_tlast,   // run_last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = ibfd_pkg::CFG_W;

  logic [CW-1:0] width_q, width_d, height_q, height_d;
  logic          accept, push, cfg_wr;
  logic [ibfd_pkg::PIX_W-1:0] pix;
  ibfd_pkg::ibfd_job_t  job;
  ibfd_pkg::ibfd_site_t warn;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    unique case (ibfd_pkg::ibfd_reg_e'(paddr[2]))
      ibfd_pkg::REG_WIDTH: begin
        prdata = 32'(width_q);
        if (cfg_wr) width_d = pwdata[CW-1:0];
      end
      ibfd_pkg::REG_HEIGHT: begin
        prdata = 32'(height_q);
        if (cfg_wr) height_d = pwdata[CW-1:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CW'(1);
      height_q <= CW'(1);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // red in the high byte, as the stream reads it MSB first
  assign pix    = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
  assign accept = s_axis_tvalid && s_axis_tready;

  ibfd_intake #(
    .MAX_DIM (MAX_DIM)
  ) u_intake (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .width_i  (width_q),
    .height_i (height_q),
    .pix_i    (pix),
    .accept_i (accept),
    .job_o    (job),
    .push_o   (push)
  );

  ibfd_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .push_i      (push),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .warn_o      (warn),
    .warn_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {warn.pix[7:0], warn.pix[15:8], warn.pix[23:16], warn.y, warn.x};

endmodule

FILE: tb/sv/testbench.sv
module testbench;

  localparam int MAX_DIM = 4096;

  typedef struct packed {
    logic [ibfd_pkg::COORD_W-1:0] x;
    logic [ibfd_pkg::COORD_W-1:0] y;
    logic [7:0]                   red;
    logic [7:0]                   green;
    logic [7:0]                   blue;
    logic                         last;
  } warning_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // red_in, green_in, blue_in
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // warn_x, warn_y, warn_red, warn_green, warn_blue
  logic        m_axis_tlast;        // run_last
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  isolated_bit_flip_detector #(.MAX_DIM(MAX_DIM)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic [ibfd_pkg::CFG_W-1:0] cfg_width = 13'd1;
  logic [ibfd_pkg::CFG_W-1:0] cfg_height = 13'd1;
  logic [ibfd_pkg::PIX_W-1:0] mdl_held = '0;
  logic [1:0]                 mdl_earlier = '0;
  bit                         mdl_held_valid = 1'b0;
  logic [31:0]                mdl_col = '0;
  logic [31:0]                mdl_row = '0;
  logic [ibfd_pkg::PIX_W-1:0] mdl_pending = '0;

  warning_t    warn_q[$];
  int unsigned fail_count = 0;
  int unsigned shown = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int          rx_stall = 0;
  int          rx_pick;

  function automatic logic [31:0] dim_of(input logic [ibfd_pkg::CFG_W-1:0] v);
    if (v == '0) return 32'd1;
    if (v > MAX_DIM) return MAX_DIM;
    return {19'd0, v};
  endfunction

  // Bit p is stream bit p of the pixel; window is two earlier bits, pixel, next bit
  function automatic logic [ibfd_pkg::PIX_W-1:0] isolated_flags(input logic [1:0] e2,
      input logic [ibfd_pkg::PIX_W-1:0] pix, input logic nxt, input int lo, input int hi);
    logic [26:0]                s;
    logic [ibfd_pkg::PIX_W-1:0] f;
    s = {e2, pix, nxt};
    f = '0;
    for (int p = lo; p <= hi; p++) begin
      if (s[26-p] == s[25-p] && s[23-p] == s[25-p] && s[24-p] != s[25-p]) f[p] = 1'b1;
    end
    return f;
  endfunction

  function automatic int push_site(input logic [ibfd_pkg::PIX_W-1:0] pix,
      input logic [ibfd_pkg::PIX_W-1:0] flags, input logic [31:0] col,
      input logic [31:0] row, input logic [31:0] h, input int idx, input int total);
    warning_t                   wn;
    logic [ibfd_pkg::PIX_W-1:0] v;
    logic [31:0]                yv;
    yv = h - 1 - row;
    for (int p = 0; p < ibfd_pkg::PIX_W; p++) begin
      if (flags[p]) begin
        v = pix ^ ({1'b1, 23'd0} >> p);
        wn.x = col[ibfd_pkg::COORD_W-1:0];
        wn.y = yv[ibfd_pkg::COORD_W-1:0];
        wn.red = v[23:16];
        wn.green = v[15:8];
        wn.blue = v[7:0];
        idx++;
        wn.last = (idx == total);
        warn_q.push_back(wn);
      end
    end
    return idx;
  endfunction

  function automatic void predict_pixel(input logic [ibfd_pkg::PIX_W-1:0] pix);
    logic [31:0]                w, h, held_col, held_row;
    logic [ibfd_pkg::PIX_W-1:0] held_px, held_flags, own_flags;
    bit                         starts, closes;
    int                         lo, total, idx;
    w = dim_of(cfg_width);
    h = dim_of(cfg_height);
    held_flags = '0;
    held_px = '0;
    held_col = '0;
    held_row = '0;
    if (mdl_held_valid) begin
      held_flags = mdl_pending |
                   isolated_flags(mdl_earlier, mdl_held, pix[ibfd_pkg::PIX_W-1], 23, 23);
      held_px = mdl_held;
      held_col = mdl_col;
      held_row = mdl_row;
      mdl_earlier = mdl_held[1:0];
      mdl_col = mdl_col + 1;
      if (mdl_col >= w) begin
        mdl_col = 0;
        mdl_row = mdl_row + 1;
        if (mdl_row >= h) mdl_row = 0;
      end
    end
    starts = (mdl_col == 0) && (mdl_row == 0);
    if (starts) mdl_earlier = 2'b00;
    lo = starts ? 2 : 0;
    closes = (mdl_col == w - 1) && (mdl_row == h - 1);
    own_flags = isolated_flags(mdl_earlier, pix, 1'b0, lo, 22);
    total = $countones(held_flags) + (closes ? $countones(own_flags) : 0);
    idx = push_site(held_px, held_flags, held_col, held_row, h, 0, total);
    if (closes) begin
      idx = push_site(pix, own_flags, mdl_col, mdl_row, h, idx, total);
      mdl_held_valid = 1'b0;
      mdl_held = '0;
      mdl_earlier = '0;
      mdl_col = '0;
      mdl_row = '0;
      mdl_pending = '0;
    end else begin
      mdl_held = pix;
      mdl_pending = own_flags;
      mdl_held_valid = 1'b1;
    end
  endfunction

  function automatic void check_warning(input warning_t got);
    warning_t want;
    if (warn_q.size() == 0) begin
      fail_count++;
      if (shown < 40) begin
        shown++;
        $display("%0t: unexpected warning x=%0d y=%0d rgb=%h_%h_%h last=%b", $time,
                 got.x, got.y, got.red, got.green, got.blue, got.last);
      end
    end else begin
      want = warn_q.pop_front();
      if (got !== want) begin
        fail_count++;
        if (shown < 40) begin
          shown++;
          $display("%0t: warning mismatch, expected x=%0d y=%0d rgb=%h_%h_%h last=%b",
                   $time, want.x, want.y, want.red, want.green, want.blue, want.last);
          $display("%0t:                   actual   x=%0d y=%0d rgb=%h_%h_%h last=%b",
                   $time, got.x, got.y, got.red, got.green, got.blue, got.last);
        end
      end
    end
  endfunction

  // Predict on accepted pixels first, then compare accepted warnings
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        predict_pixel({s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]});
      if (m_axis_tvalid && m_axis_tready)
        check_warning({m_axis_tdata[11:0], m_axis_tdata[23:12], m_axis_tdata[31:24],
                       m_axis_tdata[39:32], m_axis_tdata[47:40], m_axis_tlast});
    end
  end

  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i) begin
    if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      m_axis_tready <= 1'b0;
    end else begin
      rx_pick = pick_gap(rx_idle_on);
      if (rx_pick > 0) begin
        rx_stall <= rx_pick - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_pixel(input logic [ibfd_pkg::PIX_W-1:0] pix);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {pix[7:0], pix[15:8], pix[23:16]};
    do @(posedge clk_i); while (!s_axis_tready);
    gap = pick_gap(tx_idle_on);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= 24'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop the request and hold until every predicted warning has been seen
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (warn_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input ibfd_pkg::ibfd_reg_e idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (idx == ibfd_pkg::REG_WIDTH) cfg_width = data[ibfd_pkg::CFG_W-1:0];
    else cfg_height = data[ibfd_pkg::CFG_W-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_check(input ibfd_pkg::ibfd_reg_e idx);
    logic [ibfd_pkg::CFG_W-1:0] want;
    want = (idx == ibfd_pkg::REG_WIDTH) ? cfg_width : cfg_height;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[ibfd_pkg::CFG_W-1:0] !== want) begin
      fail_count++;
      $display("%0t: register %s readback, expected %0d actual %0d", $time, idx.name(),
               want, prdata[ibfd_pkg::CFG_W-1:0]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Upper bits of the write data are junk half the time
  task automatic set_size(input logic [ibfd_pkg::CFG_W-1:0] w,
                          input logic [ibfd_pkg::CFG_W-1:0] h);
    logic [31:0] d;
    d = $urandom;
    d[ibfd_pkg::CFG_W-1:0] = w;
    if ($urandom_range(0, 1)) d[31:ibfd_pkg::CFG_W] = '0;
    apb_write(ibfd_pkg::REG_WIDTH, d);
    d = $urandom;
    d[ibfd_pkg::CFG_W-1:0] = h;
    if ($urandom_range(0, 1)) d[31:ibfd_pkg::CFG_W] = '0;
    apb_write(ibfd_pkg::REG_HEIGHT, d);
    apb_check(ibfd_pkg::REG_WIDTH);
    apb_check(ibfd_pkg::REG_HEIGHT);
  endtask

  function automatic logic [ibfd_pkg::PIX_W-1:0] make_pixel();
    logic [ibfd_pkg::PIX_W-1:0] v;
    int                         k;
    k = $urandom_range(0, 9);
    if (k < 4) begin
      v = ibfd_pkg::PIX_W'($urandom);
    end else if (k < 8) begin
      v = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
      repeat ($urandom_range(1, 3)) v[$urandom_range(0, ibfd_pkg::PIX_W-1)] ^= 1'b1;
    end else if (k == 8) begin
      v = $urandom_range(0, 1) ? 24'h249249 : 24'hDB6DB6;
    end else begin
      case ($urandom_range(0, 3))
        0: v = 24'h555555;
        1: v = 24'hAAAAAA;
        2: v = 24'h000000;
        default: v = 24'hFFFFFF;
      endcase
    end
    return v;
  endfunction

  task automatic test_register_access();
    apb_check(ibfd_pkg::REG_WIDTH);
    apb_check(ibfd_pkg::REG_HEIGHT);
    set_size(ibfd_pkg::CFG_W'($urandom), ibfd_pkg::CFG_W'($urandom));
  endtask

  // Every pixel is a whole image: first two and last bit can never be flagged
  task automatic test_single_pixel_images();
    wait_drained();
    set_size(13'd1, 13'd1);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h800000);
    send_pixel(24'h200000);
    send_pixel(24'hDFFFFD);
    send_pixel(24'h000002);
  endtask

  // Flags that need bits of the neighbouring pixels, and a fully loaded closing step
  task automatic test_stream_across_pixels();
    wait_drained();
    set_size(13'd3, 13'd2);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h7FFFFF);
    send_pixel(24'h000001);
    send_pixel(24'h000000);
    send_pixel(24'h249249);
    send_pixel(24'h249249);
    send_pixel(24'h800000);
    send_pixel(24'hDB6DB6);
  endtask

  // Shrink width and height while a pixel is held; row past the height wraps warn_y
  task automatic test_resize_mid_image();
    wait_drained();
    set_size(13'd8, 13'd4);
    repeat (3) send_pixel(make_pixel());
    wait_drained();
    set_size(13'd2, 13'd4);
    repeat (2) send_pixel(make_pixel());
    wait_drained();
    set_size(13'd2, 13'd1);
    repeat (3) send_pixel(make_pixel());
  endtask

  task automatic test_size_extremes();
    wait_drained();
    set_size(13'd0, 13'd8191);
    repeat (3) send_pixel(make_pixel());
    wait_drained();
    set_size(13'd8191, 13'd0);
    repeat (2) send_pixel(make_pixel());
    wait_drained();
    set_size(13'd4096, 13'd4096);
    repeat (2) send_pixel(make_pixel());
  endtask

  function automatic logic [ibfd_pkg::CFG_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return ibfd_pkg::CFG_W'($urandom_range(1, 5));
    if (r < 63) return 13'd0;
    if (r < 71) return 13'd1;
    if (r < 79) return 13'd4096;
    if (r < 86) return 13'd8191;
    return ibfd_pkg::CFG_W'($urandom_range(0, 8191));
  endfunction

  task automatic test_random_images();
    int n;
    for (int ph = 0; ph < 12; ph++) begin
      wait_drained();
      if (ph == 0) set_size(13'd1, 13'd1);
      else set_size(pick_size(), pick_size());
      tx_idle_on = (ph % 5 != 2);
      rx_idle_on = (ph % 4 != 3);
      n = $urandom_range(23, 40);
      for (int i = 0; i < n; i++) begin
        if (ph == 4 && i == n / 2) wait_drained();
        send_pixel(make_pixel());
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_access();
    test_single_pixel_images();
    test_stream_across_pixels();
    test_resize_mid_image();
    test_size_extremes();
    test_random_images();
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && warn_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #15000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
hdl/ibfd_pkg.sv
hdl/ibfd_lane.sv
hdl/ibfd_intake.sv
hdl/ibfd_merge.sv
hdl/isolated_bit_flip_detector.sv
tb/sv/testbench.sv
